/* sv/dual_encoder_period_speed_meter_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual encoder period speed meter
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_ENCODER_PERIOD_SPEED_METER_DEFINES_SVH
`define DUAL_ENCODER_PERIOD_SPEED_METER_DEFINES_SVH

// Same-cycle implication.
`define DESM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/desm_pkg.sv */
// ----------------------------------------------------------------------------
// Dual encoder period speed meter package
// Shared widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package desm_pkg;

  localparam int unsigned COUNTER_BITS_DEF  = 16;
  localparam int unsigned OVERFLOW_BITS_DEF = 8;

  localparam int unsigned CAPTURE_W = 16;
  localparam int unsigned FIELD_W   = 24;
  localparam int unsigned REM_W     = 2;

  localparam logic [FIELD_W-1:0] SCALE_RESET = 24'd3463235;
  localparam logic [REM_W-1:0]   REM_ARM     = 2'd2;
  localparam logic [REM_W-1:0]   REM_LAST    = 2'd1;

  localparam logic KIND_ARM   = 1'b0;
  localparam logic KIND_TIMER = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 overflow;
    logic                 wheel1_hit;
    logic [CAPTURE_W-1:0] wheel1_capture;
    logic                 wheel2_hit;
    logic [CAPTURE_W-1:0] wheel2_capture;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] wheel1_period;
    logic [FIELD_W-1:0] wheel2_period;
    logic [FIELD_W-1:0] wheel1_speed;
    logic [FIELD_W-1:0] wheel2_speed;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;       // input transaction this cycle
    logic div_start;  // launch both speed divisions
    logic out_load;   // move finished result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic complete;   // current item finishes the measurement
    logic div_done;   // both divisions finished
  } status_t;

endpackage

/* sv/desm_item_if.sv */
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one timer or arm item.
// ----------------------------------------------------------------------------
interface desm_item_if;
  import desm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 overflow;
  logic                 wheel1_hit;
  logic [CAPTURE_W-1:0] wheel1_capture;
  logic                 wheel2_hit;
  logic [CAPTURE_W-1:0] wheel2_capture;

  modport source (
    output valid, kind, overflow, wheel1_hit, wheel1_capture, wheel2_hit, wheel2_capture,
    input  ready
  );

  modport sink (
    input  valid, kind, overflow, wheel1_hit, wheel1_capture, wheel2_hit, wheel2_capture,
    output ready
  );

endinterface

/* sv/desm_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying both periods and both speeds.
// ----------------------------------------------------------------------------
interface desm_result_if;
  import desm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] wheel1_period;
  logic [FIELD_W-1:0] wheel2_period;
  logic [FIELD_W-1:0] wheel1_speed;
  logic [FIELD_W-1:0] wheel2_speed;

  modport source (
    output valid, wheel1_period, wheel2_period, wheel1_speed, wheel2_speed,
    input  ready
  );

  modport sink (
    input  valid, wheel1_period, wheel2_period, wheel1_speed, wheel2_speed,
    output ready
  );

endinterface

/* sv/desm_divider.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module desm_divider #(
  parameter int unsigned W = desm_pkg::FIELD_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] count_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     quo_q;
  logic [W-1:0]     divisor_q;

  logic [W:0] shifted;
  logic [W:0] diff;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        count_q <= CNT_W'(W);
      end else if (busy_q) begin
        count_q <= count_q - 1'b1;
        if (count_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Payload: shift in one quotient bit per step. The remainder stays below
  // the divisor, so it always fits in W bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* sv/desm_ctrl.sv */
// ----------------------------------------------------------------------------
// Controller
// Sequences item intake, speed division and the output register.
// ----------------------------------------------------------------------------
`include "dual_encoder_period_speed_meter_defines.svh"

module desm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  desm_pkg::status_t status_i,
  output desm_pkg::cmd_t    cmd_o
);
  import desm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   div_start_q;

  always_comb begin
    cmd_o.take      = in_valid_i && in_ready_q;
    cmd_o.div_start = div_start_q;
    cmd_o.out_load  = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q && status_i.complete) begin
            state_q     <= S_DIV;
            in_ready_q  <= 1'b0;
            div_start_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (status_i.div_done) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!out_valid_q || out_ready_i) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `DESM_ASSERT_IMP(a_take_in_idle, cmd_o.take, state_q == S_IDLE, "item taken while busy")
  `DESM_ASSERT_IMP(a_load_no_clobber, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwritten")
  `DESM_ASSERT_NEXT(a_done_to_load, (state_q == S_DIV) && status_i.div_done, (state_q == S_LOAD) && !in_ready_q, "division end lost")

endmodule

/* sv/desm_datapath.sv */
// ----------------------------------------------------------------------------
// Datapath
// Per-wheel capture state, period arithmetic, speed dividers, output register.
// ----------------------------------------------------------------------------
module desm_datapath #(
  parameter int unsigned COUNTER_BITS  = desm_pkg::COUNTER_BITS_DEF,
  parameter int unsigned OVERFLOW_BITS = desm_pkg::OVERFLOW_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              scale_we_i,
  input  logic [desm_pkg::FIELD_W-1:0]      scale_wdata_i,
  input  desm_pkg::item_t                   item_i,
  input  desm_pkg::cmd_t                    cmd_i,
  output desm_pkg::status_t                 status_o,
  output desm_pkg::result_t                 result_o
);
  import desm_pkg::*;

  localparam int unsigned PW = COUNTER_BITS + OVERFLOW_BITS + 2;
  localparam int unsigned EW = (PW > 26) ? PW : 26;

  localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = '1;

  function automatic logic [FIELD_W-1:0] period_of(
    input logic [COUNTER_BITS-1:0]  cap,
    input logic [COUNTER_BITS-1:0]  last,
    input logic [OVERFLOW_BITS-1:0] ovf
  );
    logic [EW-1:0] p;
    p = EW'(cap) - EW'(last) + (EW'(ovf) << COUNTER_BITS);
    if (p[EW-1]) begin
      period_of = '0;
    end else if (|p[EW-2:FIELD_W]) begin
      period_of = '1;
    end else begin
      period_of = p[FIELD_W-1:0];
    end
  endfunction

  logic [FIELD_W-1:0]       scale_q;
  logic [REM_W-1:0]         rem1_q, rem1_d, rem2_q, rem2_d;
  logic [OVERFLOW_BITS-1:0] ovf1_q, ovf1_d, ovf2_q, ovf2_d;
  logic [COUNTER_BITS-1:0]  last1_q, last1_d, last2_q, last2_d;
  logic [FIELD_W-1:0]       delta1_q, delta1_d, delta2_q, delta2_d;
  logic [COUNTER_BITS-1:0]  cap1, cap2;
  logic                     took1, took2, complete;
  logic                     done1, done2;
  logic [FIELD_W-1:0]       quo1, quo2;
  result_t                  result_q;

  assign cap1 = COUNTER_BITS'(item_i.wheel1_capture);
  assign cap2 = COUNTER_BITS'(item_i.wheel2_capture);

  always_comb begin
    rem1_d   = rem1_q;
    rem2_d   = rem2_q;
    ovf1_d   = ovf1_q;
    ovf2_d   = ovf2_q;
    last1_d  = last1_q;
    last2_d  = last2_q;
    delta1_d = delta1_q;
    delta2_d = delta2_q;
    took1    = 1'b0;
    took2    = 1'b0;
    complete = 1'b0;
    if (item_i.kind == KIND_ARM) begin
      rem1_d = REM_ARM;
      rem2_d = REM_ARM;
    end else if (item_i.overflow) begin
      // Count overflows only between the first and second capture.
      if (rem1_q == REM_LAST && ovf1_q != OVF_MAX) begin
        ovf1_d = ovf1_q + 1'b1;
      end
      if (rem2_q == REM_LAST && ovf2_q != OVF_MAX) begin
        ovf2_d = ovf2_q + 1'b1;
      end
    end else begin
      if (item_i.wheel1_hit && rem1_q != '0) begin
        took1    = 1'b1;
        delta1_d = period_of(cap1, last1_q, ovf1_q);
        last1_d  = cap1;
        rem1_d   = rem1_q - 1'b1;
      end
      if (item_i.wheel2_hit && rem2_q != '0) begin
        took2    = 1'b1;
        delta2_d = period_of(cap2, last2_q, ovf2_q);
        last2_d  = cap2;
        rem2_d   = rem2_q - 1'b1;
      end
      if ((took1 || took2) && rem1_d == '0 && rem2_d == '0) begin
        complete = 1'b1;
        ovf1_d   = '0;
        ovf2_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      rem1_q   <= '0;
      rem2_q   <= '0;
      ovf1_q   <= '0;
      ovf2_q   <= '0;
      last1_q  <= '0;
      last2_q  <= '0;
      delta1_q <= '0;
      delta2_q <= '0;
    end else begin
      if (scale_we_i) begin
        scale_q <= scale_wdata_i;
      end
      if (cmd_i.take) begin
        rem1_q   <= rem1_d;
        rem2_q   <= rem2_d;
        ovf1_q   <= ovf1_d;
        ovf2_q   <= ovf2_d;
        last1_q  <= last1_d;
        last2_q  <= last2_d;
        delta1_q <= delta1_d;
        delta2_q <= delta2_d;
      end
    end
  end

  desm_divider #(
    .W (FIELD_W)
  ) u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (scale_q),
    .divisor_i  (delta1_q),
    .done_o     (done1),
    .quotient_o (quo1)
  );

  desm_divider #(
    .W (FIELD_W)
  ) u_div2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (scale_q),
    .divisor_i  (delta2_q),
    .done_o     (done2),
    .quotient_o (quo2)
  );

  // Periods stay put until the next item is taken, after the load.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q.wheel1_period <= delta1_q;
      result_q.wheel2_period <= delta2_q;
      result_q.wheel1_speed  <= (delta1_q == '0) ? '0 : quo1;
      result_q.wheel2_speed  <= (delta2_q == '0) ? '0 : quo2;
    end
  end

  assign status_o.complete = complete;
  assign status_o.div_done = done1 && done2;
  assign result_o          = result_q;

endmodule

/* sv/dual_encoder_period_speed_meter.sv */
// ----------------------------------------------------------------------------
// Dual encoder period speed meter
// Two-wheel input-capture tachometer: periods and speeds from timer captures.
// ----------------------------------------------------------------------------
// An arm transaction (kind 0) gives each wheel two captures to collect. Timer
// transactions (kind 1) either report a timer overflow, which bumps the
// saturating overflow count of each wheel that sits between its first and
// second capture, or carry captures: each hit wheel gets period = capture -
// previous capture + overflows * 2^COUNTER_BITS, clamped to 0..2^24-1. When a
// capture transaction leaves both wheels done, the overflow counts clear and
// one result goes out with both periods and speed = speed_scale / period
// (zero for a zero period). An item that does not finish a measurement leaves
// the block ready for the next one. A finishing item holds off input while
// the launch register, the two parallel bit-serial 24-bit dividers, their
// done flag and the hand-over to the output register follow in turn; the
// hand-over, and so the result, is held back only while an earlier result
// still waits. The output register lets the next item in while a result
// waits; a second result waits for the first to be taken.
// Write speed_scale only while the block is idle.
// ----------------------------------------------------------------------------
module dual_encoder_period_speed_meter #(
  parameter int unsigned COUNTER_BITS  = desm_pkg::COUNTER_BITS_DEF,
  parameter int unsigned OVERFLOW_BITS = desm_pkg::OVERFLOW_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         speed_scale_we_i,
  input  logic [desm_pkg::FIELD_W-1:0] speed_scale_wdata_i,
  desm_item_if.sink                    item_i,
  desm_result_if.source                result_o
);
  import desm_pkg::*;

  item_t   item;
  result_t result;
  cmd_t    cmd;
  status_t status;

  // Gather the channel fields into one item word.
  always_comb begin
    item.kind           = item_i.kind;
    item.overflow       = item_i.overflow;
    item.wheel1_hit     = item_i.wheel1_hit;
    item.wheel1_capture = item_i.wheel1_capture;
    item.wheel2_hit     = item_i.wheel2_hit;
    item.wheel2_capture = item_i.wheel2_capture;
  end

  // Sequencing: intake, divide, load the output register.
  desm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Capture state, period math, dividers and the result register.
  desm_datapath #(
    .COUNTER_BITS  (COUNTER_BITS),
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scale_we_i    (speed_scale_we_i),
    .scale_wdata_i (speed_scale_wdata_i),
    .item_i        (item),
    .cmd_i         (cmd),
    .status_o      (status),
    .result_o      (result)
  );

  assign result_o.wheel1_period = result.wheel1_period;
  assign result_o.wheel2_period = result.wheel2_period;
  assign result_o.wheel1_speed  = result.wheel1_speed;
  assign result_o.wheel2_speed  = result.wheel2_speed;

endmodule

/* sim/tb_dual_encoder_period_speed_meter.sv */
// ----------------------------------------------------------------------------
// Testbench for the dual encoder period speed meter
// Drives arm, overflow and capture transactions through the item channel and
// checks every result against an in-bench model of both wheels, across
// several speed_scale settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_dual_encoder_period_speed_meter;
  import desm_pkg::*;

  localparam int unsigned OVF_W        = OVERFLOW_BITS_DEF;
  localparam longint      FIELD_MAX    = 64'hFF_FFFF;
  localparam int unsigned DRAIN_CYCLES = 40;       // margin for a finishing item to run out
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned PHASE_ITEMS  = 350;
  localparam int unsigned LONG_HOLD    = 600;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks both wheels and holds the readings still to come
  // --------------------------------------------------------------------------
  class wheel_speed_scoreboard;
    logic [FIELD_W-1:0]   speed_scale;
    logic [REM_W-1:0]     remaining[2];
    logic [OVF_W-1:0]     overflows[2];
    logic [CAPTURE_W-1:0] last_capture[2];
    logic [FIELD_W-1:0]   period[2];
    result_t              expected_readings[$];
    int                   mismatches;

    function new();
      speed_scale = SCALE_RESET;
      for (int w = 0; w < 2; w++) begin
        remaining[w]    = '0;
        overflows[w]    = '0;
        last_capture[w] = '0;
        period[w]       = '0;
      end
      mismatches = 0;
    endfunction

    // Take one capture on a wheel; returns 1 when the wheel was hit and still had one to take.
    function bit take_capture(int w, logic hit, logic [CAPTURE_W-1:0] cap);
      longint span;
      if (!hit || remaining[w] == '0) return 1'b0;
      span = longint'(cap) - longint'(last_capture[w]) +
             (longint'(overflows[w]) << CAPTURE_W);
      if (span < 0) span = 0;
      if (span > FIELD_MAX) span = FIELD_MAX;
      period[w]       = span[FIELD_W-1:0];
      last_capture[w] = cap;
      remaining[w]    = remaining[w] - 1'b1;
      return 1'b1;
    endfunction

    function logic [FIELD_W-1:0] speed_for(logic [FIELD_W-1:0] p);
      if (p == '0) return '0;
      return speed_scale / p;
    endfunction

    function void note_item(item_t it);
      bit      took[2];
      result_t r;
      if (it.kind == KIND_ARM) begin
        remaining[0] = REM_ARM;
        remaining[1] = REM_ARM;
        return;
      end
      if (it.overflow) begin
        for (int w = 0; w < 2; w++)
          if (remaining[w] == REM_LAST && overflows[w] != '1)
            overflows[w] = overflows[w] + 1'b1;
        return;
      end
      took[0] = take_capture(0, it.wheel1_hit, it.wheel1_capture);
      took[1] = take_capture(1, it.wheel2_hit, it.wheel2_capture);
      if (!(took[0] || took[1]) || remaining[0] != '0 || remaining[1] != '0) return;
      overflows[0]    = '0;
      overflows[1]    = '0;
      r.wheel1_period = period[0];
      r.wheel2_period = period[1];
      r.wheel1_speed  = speed_for(period[0]);
      r.wheel2_speed  = speed_for(period[1]);
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] exp_v,
                                logic [FIELD_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_reading(result_t got);
      result_t exp_r;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual periods %0d %0d speeds %0d %0d",
                 $time, got.wheel1_period, got.wheel2_period, got.wheel1_speed,
                 got.wheel2_speed);
        mismatches++;
        return;
      end
      exp_r = expected_readings.pop_front();
      compare_field("wheel1_period", exp_r.wheel1_period, got.wheel1_period);
      compare_field("wheel2_period", exp_r.wheel2_period, got.wheel2_period);
      compare_field("wheel1_speed",  exp_r.wheel1_speed,  got.wheel1_speed);
      compare_field("wheel2_speed",  exp_r.wheel2_speed,  got.wheel2_speed);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               speed_scale_we_i;
  logic [FIELD_W-1:0] speed_scale_wdata_i;

  desm_item_if   item_bus ();
  desm_result_if result_bus ();

  dual_encoder_period_speed_meter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .speed_scale_we_i    (speed_scale_we_i),
    .speed_scale_wdata_i (speed_scale_wdata_i),
    .item_i              (item_bus),
    .result_o            (result_bus)
  );

  wheel_speed_scoreboard sb = new();

  bit bursts_on = 1'b1;   // random idle bursts on both channels
  int long_hold = 0;      // cycles the result side still has to hold off
  int items_sent = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Give up on a hung block; the limit sits far above the slowest correct run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Result side: update ready at the falling edge. Serve a long hold first,
  // then any running stall burst, else start a new burst now and then.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        long_hold--;
        result_bus.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready = 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        result_bus.ready = 1'b0;
      end else begin
        result_bus.ready = 1'b1;
      end
    end
  end

  // Check every result transaction at the rising edge it is taken.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got.wheel1_period = result_bus.wheel1_period;
      got.wheel2_period = result_bus.wheel2_period;
      got.wheel1_speed  = result_bus.wheel1_speed;
      got.wheel2_speed  = result_bus.wheel2_speed;
      sb.check_reading(got);
    end
  end

  // --------------------------------------------------------------------------
  // Item side
  // --------------------------------------------------------------------------
  function automatic item_t mk_item(logic kind, logic ovf, logic h1,
                                    logic [CAPTURE_W-1:0] c1, logic h2,
                                    logic [CAPTURE_W-1:0] c2);
    item_t it;
    it.kind           = kind;
    it.overflow       = ovf;
    it.wheel1_hit     = h1;
    it.wheel1_capture = c1;
    it.wheel2_hit     = h2;
    it.wheel2_capture = c2;
    return it;
  endfunction

  function automatic item_t noise_item();
    return mk_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), CAPTURE_W'($urandom),
                   1'($urandom_range(0, 1)), CAPTURE_W'($urandom));
  endfunction

  // Mostly near the previous capture or anywhere, sometimes at the extremes.
  function automatic logic [CAPTURE_W-1:0] pick_capture(logic [CAPTURE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return prev + CAPTURE_W'($urandom_range(0, 400));
      default: return CAPTURE_W'($urandom);
    endcase
  endfunction

  // Present one transaction at the falling edge, possibly after an idle
  // burst, and hold it until the block takes it.
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      item_bus.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    item_bus.valid          = 1'b1;
    item_bus.kind           = it.kind;
    item_bus.overflow       = it.overflow;
    item_bus.wheel1_hit     = it.wheel1_hit;
    item_bus.wheel1_capture = it.wheel1_capture;
    item_bus.wheel2_hit     = it.wheel2_hit;
    item_bus.wheel2_capture = it.wheel2_capture;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
  endtask

  // Drop valid once the last transaction of a stretch has gone in.
  task automatic stop_items();
    @(negedge clk_i);
    item_bus.valid = 1'b0;
  endtask

  // Wait for every expected reading, then let a finishing item run out.
  task automatic wait_drained();
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [FIELD_W-1:0] value);
    @(negedge clk_i);
    speed_scale_we_i    = 1'b1;
    speed_scale_wdata_i = value;
    sb.speed_scale      = value;
    @(negedge clk_i);
    speed_scale_we_i    = 1'b0;
  endtask

  // One arm followed by captures until both wheels are done, with overflows
  // and a little noise mixed in. With long_run set, hold both wheels between
  // their captures for 300 overflows to drive the counts into saturation.
  task automatic run_measurement(input bit long_run);
    int                   left[2];
    logic                 hit[2];
    logic [CAPTURE_W-1:0] cap[2];
    logic [CAPTURE_W-1:0] prev[2];
    item_t                it;
    left = '{2, 2};
    prev[0] = CAPTURE_W'($urandom);
    prev[1] = CAPTURE_W'($urandom);
    send_item(mk_item(KIND_ARM, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      CAPTURE_W'($urandom), 1'($urandom_range(0, 1)),
                      CAPTURE_W'($urandom)));
    while (left[0] > 0 || left[1] > 0) begin
      if (long_run && left[0] == 1 && left[1] == 1) begin
        long_run = 1'b0;
        repeat (300)
          send_item(mk_item(KIND_TIMER, 1'b1, 1'($urandom_range(0, 1)),
                            CAPTURE_W'($urandom), 1'($urandom_range(0, 1)),
                            CAPTURE_W'($urandom)));
      end else if ($urandom_range(0, 29) == 0) begin
        // Stray transaction inside the sequence; follow what it does.
        it = noise_item();
        send_item(it);
        if (it.kind == KIND_ARM) begin
          left = '{2, 2};
        end else if (!it.overflow) begin
          if (it.wheel1_hit && left[0] > 0) left[0]--;
          if (it.wheel2_hit && left[1] > 0) left[1]--;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        send_item(mk_item(KIND_TIMER, 1'b1, 1'($urandom_range(0, 1)), CAPTURE_W'($urandom),
                          1'($urandom_range(0, 1)), CAPTURE_W'($urandom)));
      end else begin
        for (int w = 0; w < 2; w++) begin
          if (left[w] > 0) hit[w] = 1'($urandom_range(0, 1));
          else hit[w] = ($urandom_range(0, 5) == 0);   // stray edge on a finished wheel
          cap[w] = hit[w] ? pick_capture(prev[w]) : CAPTURE_W'($urandom);
        end
        // Force at least one edge on a wheel that still needs one.
        if (!((hit[0] && left[0] > 0) || (hit[1] && left[1] > 0))) begin
          if (left[0] > 0) begin
            hit[0] = 1'b1;
            cap[0] = pick_capture(prev[0]);
          end else begin
            hit[1] = 1'b1;
            cap[1] = pick_capture(prev[1]);
          end
        end
        send_item(mk_item(KIND_TIMER, 1'b0, hit[0], cap[0], hit[1], cap[1]));
        for (int w = 0; w < 2; w++)
          if (hit[w] && left[w] > 0) begin
            left[w]--;
            prev[w] = cap[w];
          end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_flow
    logic [FIELD_W-1:0] phase_scale[5];
    int                 target;

    // Hold every input at a known value from the first step.
    rst_ni                  = 1'b0;
    speed_scale_we_i        = 1'b0;
    speed_scale_wdata_i     = '0;
    item_bus.valid          = 1'b0;
    item_bus.kind           = KIND_ARM;
    item_bus.overflow       = 1'b0;
    item_bus.wheel1_hit     = 1'b0;
    item_bus.wheel1_capture = '0;
    item_bus.wheel2_hit     = 1'b0;
    item_bus.wheel2_capture = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, at the reset scale.
    // Edges and overflows before any arm: nothing to capture, no counting.
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'd1234, 1'b1, 16'd4321));
    send_item(mk_item(KIND_TIMER, 1'b1, 1'b0, '0, 1'b0, '0));
    // Arm with every other field set: those fields are don't-care.
    send_item(mk_item(KIND_ARM, 1'b1, 1'b1, '1, 1'b1, '1));
    // Overflow before the first capture: no count.
    send_item(mk_item(KIND_TIMER, 1'b1, 1'b0, '0, 1'b0, '0));
    // First captures at the counter extremes.
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, '0, 1'b1, '1));
    send_item(mk_item(KIND_TIMER, 1'b1, 1'b0, '0, 1'b0, '0));
    // Overflow carrying captures: captures dropped, counts still bump.
    send_item(mk_item(KIND_TIMER, 1'b1, 1'b1, 16'h5555, 1'b1, 16'hAAAA));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, '1, 1'b0, '0));
    // Wheel one already done: its edge is ignored; wheel two finishes.
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'h7777, 1'b1, '0));
    // Edges after completion give nothing.
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'd1, 1'b1, 16'd1));
    // Later capture below the earlier one, and an equal pair: zero periods.
    send_item(mk_item(KIND_ARM, 1'b0, 1'b0, '0, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'd100, 1'b1, 16'd200));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'd50, 1'b1, 16'd200));
    // Period of one tick on each wheel: speed equals the scale.
    send_item(mk_item(KIND_ARM, 1'b0, 1'b0, '0, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'hFFFE, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b0, '0, 1'b1, 16'h0010));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'hFFFF, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b0, '0, 1'b1, 16'h0011));
    // Re-arm mid-measurement: the overflow count survives the arm.
    send_item(mk_item(KIND_ARM, 1'b0, 1'b0, '0, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'h8000, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b1, 1'b0, '0, 1'b0, '0));
    send_item(mk_item(KIND_ARM, 1'b0, 1'b0, '0, 1'b0, '0));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'h8000, 1'b1, 16'h8000));
    send_item(mk_item(KIND_TIMER, 1'b0, 1'b1, 16'h8001, 1'b1, 16'h8002));
    stop_items();
    wait_drained();

    // Random phases, one scale each: zero, full scale, one, random, reset value.
    phase_scale[0] = '0;
    phase_scale[1] = '1;
    phase_scale[2] = FIELD_W'(1);
    phase_scale[3] = FIELD_W'($urandom);
    phase_scale[4] = SCALE_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      // Last phase runs flat out on both sides.
      if (ph == 4) bursts_on = 1'b0;
      // Hold off the result side for a long stretch while items keep coming,
      // so the output register fills and the block backs up its input.
      if (ph == 1) long_hold = LONG_HOLD;
      write_scale(phase_scale[ph]);
      target = items_sent + PHASE_ITEMS;
      if (ph == 0) run_measurement(1'b1);
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) send_item(noise_item());
        else run_measurement(1'b0);
      end
      stop_items();
      wait_drained();
    end

    foreach (sb.expected_readings[i]) begin
      $display("%0t: missing result, expected periods %0d %0d speeds %0d %0d, actual none",
               $time, sb.expected_readings[i].wheel1_period,
               sb.expected_readings[i].wheel2_period, sb.expected_readings[i].wheel1_speed,
               sb.expected_readings[i].wheel2_speed);
      sb.mismatches++;
    end

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/desm_pkg.sv
sv/desm_item_if.sv
sv/desm_result_if.sv
sv/desm_divider.sv
sv/desm_ctrl.sv
sv/desm_datapath.sv
sv/dual_encoder_period_speed_meter.sv
sim/tb_dual_encoder_period_speed_meter.sv
